// File: hdl/rrod_pkg.sv
// Shared constants, types and widths for the row repeat offset detector.
package rrod_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int CHANNELS  = 3;

  localparam int CHAN_N = 3;
  localparam int CHAN_W = 8;
  localparam int WORD_W = CHAN_N * CHAN_W;
  localparam int FLAG_W = CHAN_N;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CFG_W = 11;
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int NCELL = MAX_WIDTH - 1;

  localparam logic [CFG_W-1:0]  ROW_WIDTH_RST = 11'd1024;
  localparam logic [CHAN_W-1:0] MARK_VALUE    = 8'd255;
  localparam logic              REQ_PIXEL     = 1'b0;
  localparam logic              REQ_DRAIN     = 1'b1;

  typedef logic [FLAG_W-1:0] flag_t;

  typedef struct packed {
    logic              live;
    logic [WORD_W-1:0] pix;
  } tap_t;

  typedef struct packed {
    logic step;
    logic row_start;
    logic row_end;
    logic is_pixel;
  } cell_ctl_t;

endpackage

// File: hdl/rrod_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rrod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/rrod_cell.sv
// One distance cell: a pixel tap, the current row's marks and the previous row's marks.
module rrod_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrod_pkg::cell_ctl_t         ctl,
  input  logic [rrod_pkg::WORD_W-1:0] pix_i,
  input  rrod_pkg::tap_t              tap_i,
  output rrod_pkg::tap_t              tap_o,
  input  rrod_pkg::flag_t             prv_i,
  output rrod_pkg::flag_t             prv_o
);

  logic                        vld_r, vld_nxt;
  logic [rrod_pkg::WORD_W-1:0] pix_r, pix_nxt;
  rrod_pkg::flag_t             cur_r, cur_nxt;
  rrod_pkg::flag_t             prv_r, prv_nxt;
  rrod_pkg::flag_t             hit;
  rrod_pkg::flag_t             cur_upd;
  logic                        live;

  always_comb begin
    live = vld_r & ~ctl.row_start;
    for (int c = 0; c < rrod_pkg::FLAG_W; c++) begin
      if (c < rrod_pkg::CHANNELS) begin
        hit[c] = live & ctl.is_pixel &
                 (pix_i[c*rrod_pkg::CHAN_W +: rrod_pkg::CHAN_W] ==
                  pix_r[c*rrod_pkg::CHAN_W +: rrod_pkg::CHAN_W]);
      end else begin
        hit[c] = 1'b0;
      end
    end
    cur_upd = (ctl.row_start ? '0 : cur_r) | hit;

    vld_nxt = vld_r;
    pix_nxt = pix_r;
    cur_nxt = cur_r;
    prv_nxt = prv_r;
    if (ctl.step) begin
      vld_nxt = tap_i.live;
      pix_nxt = tap_i.pix;
      cur_nxt = cur_upd;
      prv_nxt = ctl.row_end ? cur_upd : prv_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cur_r <= '0;
      prv_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cur_r <= cur_nxt;
      prv_r <= prv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign tap_o.live = live;
  assign tap_o.pix  = pix_r;
  assign prv_o      = prv_r;

endmodule

// File: hdl/row_repeat_offset_detector.sv
// Top level: column control, pixel store, chain of distance cells and result register.
// Each result word is loaded into the output register in the cycle after its input word is accepted.
// Throughput: one word per cycle while not stalled; every cell compares the new pixel with its tap in that cycle.
// The pixel store is read one column ahead, so a drain word finds its stored pixel ready without waiting.
// Reset (rst_n low, synchronous) clears the column counter, the row flags, all mark cells
// and the out_word_valid flag; the pixel store is not cleared and no clearing pass runs.
module row_repeat_offset_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [rrod_pkg::CFG_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_req_type,
  input  logic [rrod_pkg::CHAN_W-1:0]       in_pixel_c0,
  input  logic [rrod_pkg::CHAN_W-1:0]       in_pixel_c1,
  input  logic [rrod_pkg::CHAN_W-1:0]       in_pixel_c2,
  output logic                              out_word_valid,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [rrod_pkg::CHAN_W-1:0]       out_c0,
  output logic [rrod_pkg::CHAN_W-1:0]       out_c1,
  output logic [rrod_pkg::CHAN_W-1:0]       out_c2,
  output logic                              out_last_in_row
);

  logic [rrod_pkg::CFG_W-1:0]  row_width_r, row_width_nxt;
  logic [rrod_pkg::COL_W-1:0]  col_r, col_nxt;
  logic                        have_prev_r, have_prev_nxt;
  rrod_pkg::flag_t             head_r, head_nxt;

  logic                        owv_r, owv_nxt;
  logic                        ov_r, ov_nxt;
  logic [rrod_pkg::CHAN_W-1:0] oc0_r, oc0_nxt;
  logic [rrod_pkg::CHAN_W-1:0] oc1_r, oc1_nxt;
  logic [rrod_pkg::CHAN_W-1:0] oc2_r, oc2_nxt;
  logic                        olast_r, olast_nxt;

  logic                        accept;
  logic                        is_pixel;
  logic                        last;
  logic [rrod_pkg::CMP_W-1:0]  col_p1;
  logic [rrod_pkg::CMP_W-1:0]  w_cfg;
  logic [rrod_pkg::CMP_W-1:0]  w_eff;
  logic [rrod_pkg::WORD_W-1:0] pix_in;
  logic [rrod_pkg::WORD_W-1:0] stale_pix;
  rrod_pkg::cell_ctl_t         ctl;

  rrod_pkg::tap_t              taps [rrod_pkg::NCELL];
  rrod_pkg::flag_t             prv  [rrod_pkg::NCELL + 1];

  assign in_stall = ~rst_n | (owv_r & out_stall);
  assign accept   = in_valid & ~in_stall;
  assign is_pixel = (in_req_type == rrod_pkg::REQ_PIXEL);
  assign pix_in   = {in_pixel_c2, in_pixel_c1, in_pixel_c0};

  always_comb begin
    w_cfg  = rrod_pkg::CMP_W'(row_width_r);
    col_p1 = rrod_pkg::CMP_W'(col_r) + rrod_pkg::CMP_W'(1);
    if (w_cfg < rrod_pkg::CMP_W'(2)) begin
      w_eff = rrod_pkg::CMP_W'(2);
    end else if (w_cfg > rrod_pkg::CMP_W'(rrod_pkg::MAX_WIDTH)) begin
      w_eff = rrod_pkg::CMP_W'(rrod_pkg::MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    last = (col_p1 >= w_eff);
  end

  always_comb begin
    ctl.step      = accept;
    ctl.row_start = (col_r == '0);
    ctl.row_end   = last;
    ctl.is_pixel  = is_pixel;
  end

  always_comb begin
    row_width_nxt = cfg_wr_en ? cfg_wr_data : row_width_r;
    col_nxt       = col_r;
    have_prev_nxt = have_prev_r;
    head_nxt      = head_r;
    if (accept) begin
      col_nxt  = last ? '0 : col_p1[rrod_pkg::COL_W-1:0];
      head_nxt = last ? '0 : prv[0];
      if (last) begin
        have_prev_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    owv_nxt   = owv_r & out_stall;
    ov_nxt    = ov_r;
    oc0_nxt   = oc0_r;
    oc1_nxt   = oc1_r;
    oc2_nxt   = oc2_r;
    olast_nxt = olast_r;
    if (accept) begin
      owv_nxt   = 1'b1;
      ov_nxt    = have_prev_r;
      oc0_nxt   = (have_prev_r & head_r[0]) ? rrod_pkg::MARK_VALUE : '0;
      oc1_nxt   = (have_prev_r & head_r[1]) ? rrod_pkg::MARK_VALUE : '0;
      oc2_nxt   = (have_prev_r & head_r[2]) ? rrod_pkg::MARK_VALUE : '0;
      olast_nxt = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= rrod_pkg::ROW_WIDTH_RST;
      col_r       <= '0;
      have_prev_r <= 1'b0;
      head_r      <= '0;
      owv_r       <= 1'b0;
    end else begin
      row_width_r <= row_width_nxt;
      col_r       <= col_nxt;
      have_prev_r <= have_prev_nxt;
      head_r      <= head_nxt;
      owv_r       <= owv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ov_r    <= ov_nxt;
    oc0_r   <= oc0_nxt;
    oc1_r   <= oc1_nxt;
    oc2_r   <= oc2_nxt;
    olast_r <= olast_nxt;
  end

  rrod_ram #(
    .WIDTH (rrod_pkg::WORD_W),
    .DEPTH (rrod_pkg::MAX_WIDTH)
  ) u_pix_ram (
    .clk     (clk),
    .wr_en   (accept & is_pixel),
    .wr_addr (col_r),
    .wr_data (pix_in),
    .rd_addr (col_nxt),
    .rd_data (stale_pix)
  );

  assign taps[0].live           = 1'b1;
  assign taps[0].pix            = is_pixel ? pix_in : stale_pix;
  assign prv[rrod_pkg::NCELL]   = '0;

  for (genvar j = 0; j < rrod_pkg::NCELL; j++) begin : g_cell
    if (j < rrod_pkg::NCELL - 1) begin : g_mid
      rrod_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .pix_i (pix_in),
        .tap_i (taps[j]),
        .tap_o (taps[j+1]),
        .prv_i (prv[j+1]),
        .prv_o (prv[j])
      );
    end else begin : g_end
      rrod_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .pix_i (pix_in),
        .tap_i (taps[j]),
        .tap_o (),
        .prv_i (prv[j+1]),
        .prv_o (prv[j])
      );
    end
  end

  assign out_word_valid  = owv_r;
  assign out_valid       = ov_r;
  assign out_c0          = oc0_r;
  assign out_c1          = oc1_r;
  assign out_c2          = oc2_r;
  assign out_last_in_row = olast_r;

  a_row_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last |=> col_r == '0)
    else $error("column counter did not wrap at the end of a row");

  a_mid_row_steps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !last |=> col_r != '0)
    else $error("column counter returned to zero in mid row");

  a_no_marks_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    owv_r && !ov_r |-> (oc0_r == '0 && oc1_r == '0 && oc2_r == '0))
    else $error("marks shown on a word without a previous row");

  a_full_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    owv_r && out_stall |-> in_stall)
    else $error("input taken while the result register is full and stalled");

endmodule
